FILE: sv/checksummed_sentence_deframer_macros.svh
// assertion helpers for the sentence deframer, sampled on clock, off during reset
`ifndef CHECKSUMMED_SENTENCE_DEFRAMER_MACROS_SVH
`define CHECKSUMMED_SENTENCE_DEFRAMER_MACROS_SVH

// same-cycle implication
`define CSD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: sv/csd_pkg.sv
`default_nettype none
package csd_pkg;

   // payload store and counter sizing
   localparam int STORE_DEPTH     = 64;
   localparam int CNT_W           = 7;
   localparam int DEF_MAX_PAYLOAD = STORE_DEPTH;

   // framing characters
   localparam logic [7:0] CH_DOLLAR   = 8'h24;
   localparam logic [7:0] CH_ASTERISK = 8'h2A;
   localparam logic [7:0] CH_NEWLINE  = 8'h0A;

   // result status codes
   typedef enum logic [1:0] {
      ST_WAITING = 2'd0,
      ST_GOOD    = 2'd1,
      ST_FAIL    = 2'd2,
      ST_PAYLOAD = 2'd3
   } status_type;

   // parse and emit phases
   typedef enum logic [6:0] {
      PH_WAIT    = 7'b0000001,
      PH_REC     = 7'b0000010,
      PH_HEX_HI  = 7'b0000100,
      PH_HEX_LO  = 7'b0001000,
      PH_NEWLINE = 7'b0010000,
      PH_READ    = 7'b0100000,
      PH_LOAD    = 7'b1000000
   } phase_type;

   // hex digit value in the low nibble, top bit set when not a hex digit
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = {1'b0, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = {1'b0, 4'(c - 8'h41 + 8'd10)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = {1'b0, 4'(c - 8'h61 + 8'd10)};
      end else begin
         v = 5'b10000;
      end
      return v;
   endfunction

endpackage
`default_nettype wire

FILE: sv/checksummed_sentence_deframer.sv
// channel  dir  handshake              payload
// req      in   req_tvalid/req_tready  req_tdata[7:0] rx_byte
// rsp      out  rsp_tvalid/rsp_tready  rsp_tdata payload_byte, payload_count;
//                                      rsp_tuser status; rsp_tlast last
//
// each received byte gives one result from the output register, except that a good frame's
// newline with stored payload gives none itself and instead emits its n payload bytes, each
// read from the registered payload memory and then loaded into the output register
// input is held off while the payload run is read out
// reset clears phase, counters and the output valid; the payload memory is not cleared,
// only entries written in the current frame are ever read
// a stalled result holds in the output register; the next byte is taken in the cycle
// that result transfers
`default_nettype none
`include "checksummed_sentence_deframer_macros.svh"

module checksummed_sentence_deframer
   import csd_pkg::*;
#(
   parameter int MAX_PAYLOAD = DEF_MAX_PAYLOAD
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata,   // [7:0] payload_byte, [14:8] payload_count, [15] zero
   output logic [1:0]       rsp_tuser,   // [1:0] status
   output logic             rsp_tlast    // last result caused by this byte
);

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_PAYLOAD);

   // payload memory, one write port on the record path, one registered read port
   logic [7:0] mem [MAX_PAYLOAD];
   logic [7:0] mem_rdata_ff;
   logic       mem_we;
   logic       mem_re;

   // parse state
   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] wp_ff, wp_in;        // bytes stored in this frame
   logic [7:0]       xor_ff, xor_in;      // running xor of stored bytes
   logic [3:0]       hi_ff, hi_in;        // first checksum digit
   logic [CNT_W-1:0] rd_ptr_ff, rd_ptr_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       rsp_status_ff, rsp_status_in;
   logic [7:0]       rsp_byte_ff, rsp_byte_in;
   logic [CNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic             rsp_last_ff, rsp_last_in;

   logic             out_free;
   logic             req_fire;
   logic [4:0]       hex;
   logic [CNT_W-1:0] rd_next;
   logic             run_done;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = out_free && (phase_ff != PH_READ) && (phase_ff != PH_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign hex        = hex_value(req_tdata);
   assign rd_next    = rd_ptr_ff + CNT_W'(1);
   assign run_done   = (rd_next == wp_ff);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_count_ff, rsp_byte_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      phase_in      = phase_ff;
      wp_in         = wp_ff;
      xor_in        = xor_ff;
      hi_in         = hi_ff;
      rd_ptr_in     = rd_ptr_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_status_in = rsp_status_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;

      // every accepted byte gives a single status result unless overridden below
      if (req_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_GOOD;
         rsp_byte_in   = 8'd0;
         rsp_count_in  = '0;
         rsp_last_in   = 1'b1;
      end

      unique case (phase_ff)
         PH_REC: begin
            if (req_fire) begin
               if (req_tdata == CH_ASTERISK) begin
                  phase_in = PH_HEX_HI;
               end else if (wp_ff >= MAX_CNT) begin
                  // store full
                  rsp_status_in = ST_FAIL;
                  phase_in      = PH_WAIT;
               end else begin
                  mem_we = 1'b1;
                  xor_in = xor_ff ^ req_tdata;
                  wp_in  = wp_ff + CNT_W'(1);
               end
            end
         end
         PH_HEX_HI: begin
            if (req_fire) begin
               if (hex[4]) begin
                  rsp_status_in = ST_FAIL;
                  phase_in      = PH_WAIT;
               end else begin
                  hi_in    = hex[3:0];
                  phase_in = PH_HEX_LO;
               end
            end
         end
         PH_HEX_LO: begin
            if (req_fire) begin
               if (hex[4] || ({hi_ff, hex[3:0]} != xor_ff)) begin
                  rsp_status_in = ST_FAIL;
                  phase_in      = PH_WAIT;
               end else begin
                  phase_in = PH_NEWLINE;
               end
            end
         end
         PH_NEWLINE: begin
            if (req_fire) begin
               if (req_tdata != CH_NEWLINE) begin
                  rsp_status_in = ST_FAIL;
                  phase_in      = PH_WAIT;
               end else if (wp_ff == '0) begin
                  // empty frame: one payload result with zero byte and count
                  rsp_status_in = ST_PAYLOAD;
                  phase_in      = PH_WAIT;
               end else begin
                  // no result for the newline itself, the run follows
                  rsp_valid_in = 1'b0;
                  rd_ptr_in    = '0;
                  phase_in     = PH_READ;
               end
            end
         end
         PH_READ: begin
            mem_re   = 1'b1;
            phase_in = PH_LOAD;
         end
         PH_LOAD: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_PAYLOAD;
               rsp_byte_in   = mem_rdata_ff;
               rsp_count_in  = wp_ff;
               rsp_last_in   = run_done;
               rd_ptr_in     = rd_next;
               phase_in      = run_done ? PH_WAIT : PH_READ;
            end
         end
         default: begin
            phase_in = PH_WAIT;
            if (req_fire) begin
               if (req_tdata == CH_DOLLAR) begin
                  phase_in = PH_REC;
                  wp_in    = '0;
                  xor_in   = 8'd0;
               end else begin
                  rsp_status_in = ST_WAITING;
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_WAIT;
         wp_ff        <= '0;
         xor_ff       <= 8'd0;
         hi_ff        <= 4'd0;
         rd_ptr_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         wp_ff        <= wp_in;
         xor_ff       <= xor_in;
         hi_ff        <= hi_in;
         rd_ptr_ff    <= rd_ptr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // payload memory ports
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wp_ff[AW-1:0]] <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         mem_rdata_ff <= mem[rd_ptr_ff[AW-1:0]];
      end
   end

   `CSD_ASSERT_NOW(a_no_input_in_run, (phase_ff == PH_READ) || (phase_ff == PH_LOAD), !req_tready, "input taken during payload run")
   `CSD_ASSERT_NOW(a_wp_in_range, 1'b1, wp_ff <= MAX_CNT, "write position beyond payload limit")
   `CSD_ASSERT_NOW(a_write_only_recording, mem_we, phase_ff == PH_REC, "payload write outside recording")
   `CSD_ASSERT_NOW(a_count_matches, rsp_valid_ff && (rsp_status_ff == ST_PAYLOAD), rsp_count_ff == wp_ff, "payload count differs from stored length")
   `CSD_ASSERT_NEXT(a_run_continues, rsp_valid_ff && rsp_tready && (rsp_status_ff == ST_PAYLOAD) && !rsp_last_ff, (phase_ff == PH_READ) || (phase_ff == PH_LOAD) || (rsp_valid_ff && (rsp_status_ff == ST_PAYLOAD)), "payload run ended early")

endmodule
`default_nettype wire
